FILE: hw/rtl/csv_field_tokenizer_unit_defines.svh
// Assertion macros used by the tokenizer port checker.
`ifndef CSV_FIELD_TOKENIZER_UNIT_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CSVFT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CSVFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/csvft_pkg.sv
// Shared types and constants of the comma-separated-values tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvft_pkg;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_SQUOTE = 8'd39;

  localparam logic [6:0] CFG_COLUMNS_RST = 7'd2;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_NL,
    CLS_COMMA,
    CLS_SPACE,
    CLS_DQUOTE,
    CLS_SQUOTE
  } byte_cls_t;

  typedef enum logic [1:0] {
    K_BYTE  = 2'd0,
    K_FIELD = 2'd1,
    K_ROW   = 2'd2,
    K_ERR   = 2'd3
  } kind_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_HDR_CNT  = 2'd1;
  localparam logic [1:0] ERR_FEW_COLS = 2'd2;
  localparam logic [1:0] ERR_NO_COMMA = 2'd3;

  typedef struct packed {
    byte_cls_t  cls;
    logic [7:0] data;
  } q_entry_t;

  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    c = CLS_OTHER;
    if (b == CH_NL) c = CLS_NL;
    else if (b == CH_COMMA) c = CLS_COMMA;
    else if (b == CH_SPACE) c = CLS_SPACE;
    else if (b == CH_DQUOTE) c = CLS_DQUOTE;
    else if (b == CH_SQUOTE) c = CLS_SQUOTE;
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/csvft_front.sv
// Input stage: accept text bytes, classify them and register the result.
`timescale 1ns / 1ps
`default_nettype none

module csvft_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_byte,
  output logic                push_valid,
  input  wire                 push_ready,
  output csvft_pkg::q_entry_t push_data
);

  logic                v_r;
  csvft_pkg::q_entry_t ent_r;

  assign in_ready   = !v_r || push_ready;
  assign push_valid = v_r;
  assign push_data  = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v_r <= 1'b1;
    end else if (push_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent_r.cls  <= csvft_pkg::classify(in_byte);
      ent_r.data <= in_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/csvft_queue.sv
// Short queue of classified bytes between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none

module csvft_queue #(
  parameter int DEPTH = csvft_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push_valid,
  output logic                push_ready,
  input  csvft_pkg::q_entry_t push_data,
  output logic                pop_valid,
  input  wire                 pop_ready,
  output csvft_pkg::q_entry_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  csvft_pkg::q_entry_t mem_r [DEPTH];
  logic [AW:0]         wr_ptr_r;
  logic [AW:0]         rd_ptr_r;
  logic                do_push;
  logic                do_pop;

  // full when both pointers sit on the same slot one lap apart
  assign push_ready = !((wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                        (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]));
  assign pop_valid  = (wr_ptr_r != rd_ptr_r);
  assign pop_data   = mem_r[rd_ptr_r[AW-1:0]];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      // wrap each pointer at the depth; the extra bit marks the lap
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r[AW-1:0] == AW'(DEPTH - 1)) ?
                    {~wr_ptr_r[AW], {AW{1'b0}}} : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r[AW-1:0] == AW'(DEPTH - 1)) ?
                    {~rd_ptr_r[AW], {AW{1'b0}}} : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/csvft_back.sv
// Back stage: field/row state machine and output register.
`timescale 1ns / 1ps
`default_nettype none

module csvft_back #(
  parameter int MAX_COLUMNS = csvft_pkg::MAX_COLUMNS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire  [6:0]          cfg_wr_data,
  input  wire                 pop_valid,
  output logic                pop_ready,
  input  csvft_pkg::q_entry_t pop_data,
  output logic                res_valid,
  input  wire                 res_ready,
  output csvft_pkg::kind_t    res_kind,
  output logic [7:0]          res_byte,
  output logic [5:0]          res_column,
  output logic                res_is_header,
  output logic [1:0]          res_error
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_PLAIN,
    PH_QUOTED,
    PH_AFTERQ,
    PH_SKIP
  } phase_t;

  phase_t           ph_r, ph_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             hdr_r, hdr_nxt;
  logic             qk_r, qk_nxt;
  logic             halted_r, halted_nxt;
  logic [6:0]       cfg_cols_r;

  logic             pop;
  logic             emit;
  csvft_pkg::kind_t kind;
  logic [7:0]       obyte;
  logic [1:0]       ecode;
  logic [7:0]       eff;
  logic [7:0]       col_p1;
  logic             last_col;
  logic             close_q;
  csvft_pkg::byte_cls_t cls;

  assign pop       = pop_valid && (!res_valid || res_ready);
  assign pop_ready = !res_valid || res_ready;
  assign cls       = pop_data.cls;

  always_comb begin
    if (cfg_cols_r == 7'd0) eff = 8'd1;
    else if (8'(cfg_cols_r) > 8'(MAX_COLUMNS)) eff = 8'(MAX_COLUMNS);
    else eff = 8'(cfg_cols_r);
  end

  assign col_p1   = 8'(col_r) + 8'd1;
  assign last_col = (col_p1 >= eff);
  assign close_q  = qk_r ? (cls == csvft_pkg::CLS_SQUOTE) : (cls == csvft_pkg::CLS_DQUOTE);

  always_comb begin
    ph_nxt     = ph_r;
    col_nxt    = col_r;
    hdr_nxt    = hdr_r;
    qk_nxt     = qk_r;
    halted_nxt = halted_r;
    emit       = 1'b0;
    kind       = csvft_pkg::K_BYTE;
    obyte      = 8'd0;
    ecode      = csvft_pkg::ERR_NONE;
    if (halted_r) begin
      // drop every beat until reset
    end else if (hdr_r) begin
      emit = 1'b1;
      if (cls == csvft_pkg::CLS_COMMA) begin
        kind = csvft_pkg::K_FIELD;
        if (8'(col_r) < 8'(MAX_COLUMNS)) col_nxt = CW'(col_p1);
      end else if (cls == csvft_pkg::CLS_NL) begin
        if (col_p1 != eff) begin
          kind       = csvft_pkg::K_ERR;
          ecode      = csvft_pkg::ERR_HDR_CNT;
          halted_nxt = 1'b1;
        end else begin
          kind    = csvft_pkg::K_ROW;
          hdr_nxt = 1'b0;
          col_nxt = '0;
          ph_nxt  = PH_START;
          qk_nxt  = 1'b0;
        end
      end else begin
        obyte = pop_data.data;
      end
    end else begin
      // shared endings: unquoted comma ends a field, newline the row
      unique case (ph_r) inside
        PH_START, PH_LEAD: begin
          if (cls == csvft_pkg::CLS_SPACE) begin
            ph_nxt = PH_LEAD;
          end else if (cls == csvft_pkg::CLS_DQUOTE || cls == csvft_pkg::CLS_SQUOTE) begin
            qk_nxt = (cls == csvft_pkg::CLS_SQUOTE);
            ph_nxt = PH_QUOTED;
          end else if (cls != csvft_pkg::CLS_NL && cls != csvft_pkg::CLS_COMMA) begin
            emit   = 1'b1;
            obyte  = pop_data.data;
            ph_nxt = PH_PLAIN;
          end
        end
        PH_PLAIN: begin
          if (cls != csvft_pkg::CLS_NL && cls != csvft_pkg::CLS_COMMA) begin
            emit  = 1'b1;
            obyte = pop_data.data;
          end
        end
        PH_QUOTED: begin
          if (close_q) begin
            ph_nxt = PH_AFTERQ;
          end else if (cls != csvft_pkg::CLS_NL) begin
            emit  = 1'b1;
            obyte = pop_data.data;
          end
        end
        PH_AFTERQ: begin
          if (cls != csvft_pkg::CLS_NL && cls != csvft_pkg::CLS_COMMA) begin
            emit       = 1'b1;
            kind       = csvft_pkg::K_ERR;
            ecode      = csvft_pkg::ERR_NO_COMMA;
            halted_nxt = 1'b1;
          end
        end
        PH_SKIP: begin
          if (cls == csvft_pkg::CLS_NL) begin
            col_nxt = '0;
            ph_nxt  = PH_START;
            qk_nxt  = 1'b0;
          end
        end
        default: begin
          ph_nxt = PH_START;
        end
      endcase

      if (ph_r != PH_SKIP) begin
        if (cls == csvft_pkg::CLS_NL) begin
          emit = 1'b1;
          if (ph_r == PH_START || !last_col) begin
            kind       = csvft_pkg::K_ERR;
            ecode      = csvft_pkg::ERR_FEW_COLS;
            halted_nxt = 1'b1;
          end else begin
            kind    = csvft_pkg::K_ROW;
            col_nxt = '0;
            ph_nxt  = PH_START;
            qk_nxt  = 1'b0;
          end
        end else if (cls == csvft_pkg::CLS_COMMA && ph_r != PH_QUOTED) begin
          emit = 1'b1;
          if (last_col) begin
            kind   = csvft_pkg::K_ROW;
            ph_nxt = PH_SKIP;
          end else begin
            kind    = csvft_pkg::K_FIELD;
            col_nxt = CW'(col_p1);
            ph_nxt  = PH_START;
            qk_nxt  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= PH_START;
      col_r      <= '0;
      hdr_r      <= 1'b1;
      qk_r       <= 1'b0;
      halted_r   <= 1'b0;
      cfg_cols_r <= csvft_pkg::CFG_COLUMNS_RST;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) cfg_cols_r <= cfg_wr_data;
      if (pop) begin
        ph_r      <= ph_nxt;
        col_r     <= col_nxt;
        hdr_r     <= hdr_nxt;
        qk_r      <= qk_nxt;
        halted_r  <= halted_nxt;
        res_valid <= emit;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_kind      <= kind;
      res_byte      <= obyte;
      res_column    <= (8'(col_r) > 8'd63) ? 6'd63 : 6'(col_r);
      res_is_header <= hdr_r;
      res_error     <= ecode;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/csv_field_tokenizer_unit.sv
// Top level of the streaming comma-separated-values field tokenizer.
// Throughput: one byte per cycle while the output is not stalled; the back state machine decides one beat a cycle.
// Path from input beat to result beat: front register, queue, output register.
// Bytes that cause no result are consumed without an output beat.
// Reset (rst_n low, synchronous) empties the queue, clears the output, restarts at the header
// and sets the column count to two; after an error all input is dropped until reset.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer_unit #(
  parameter int MAX_COLUMNS = csvft_pkg::MAX_COLUMNS_DEF,
  parameter int QUEUE_DEPTH = csvft_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [6:0]  cfg_wr_data,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,    // [7:0] data_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,   // [7:0] out_byte, [13:8] column, [15:14] error_code
  output logic [2:0]  out_tuser    // [1:0] kind, [2] is_header
);

  logic                push_valid;
  logic                push_ready;
  csvft_pkg::q_entry_t push_data;
  logic                pop_valid;
  logic                pop_ready;
  csvft_pkg::q_entry_t pop_data;
  csvft_pkg::kind_t    res_kind;
  logic [7:0]          res_byte;
  logic [5:0]          res_column;
  logic                res_is_header;
  logic [1:0]          res_error;

  csvft_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  csvft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  csvft_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_kind      (res_kind),
    .res_byte      (res_byte),
    .res_column    (res_column),
    .res_is_header (res_is_header),
    .res_error     (res_error)
  );

  assign out_tdata = {res_error, res_column, res_byte};
  assign out_tuser = {res_is_header, res_kind};

endmodule

`default_nettype wire

FILE: hw/rtl/csvft_checker.sv
// Port-level checker for the tokenizer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_field_tokenizer_unit_defines.svh"

module csvft_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata,
  input wire [2:0]  out_tuser
);

  logic is_err;
  assign is_err = (out_tuser[1:0] == csvft_pkg::K_ERR);

  `CSVFT_ASSERT_NEXT(a_stall_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result beat dropped while stalled")
  `CSVFT_ASSERT_NEXT(a_stall_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "result payload changed while stalled")
  `CSVFT_ASSERT_NOW(a_err_code, clk, rst_n, out_tvalid, is_err == (out_tdata[15:14] != csvft_pkg::ERR_NONE), "error code disagrees with kind")
  `CSVFT_ASSERT_NEXT(a_halt, clk, rst_n, out_tvalid && out_tready && is_err, !out_tvalid, "result after an error")

endmodule

bind csv_field_tokenizer_unit csvft_checker u_csvft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: sim/csv_field_tokenizer_unit_checker.sv
// Scoreboard for the tokenizer: predicts each token from accepted bytes and compares result beats.
`timescale 1ns / 1ps

module csv_field_tokenizer_unit_checker
  import csvft_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [6:0]  cfg_wr_data,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [7:0]  in_tdata,    // [7:0] data_byte
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [15:0] out_tdata,   // [7:0] out_byte, [13:8] column, [15:14] error_code
  input  wire  [2:0]  out_tuser,   // [1:0] kind, [2] is_header
  output int          outstanding,
  output int          mismatches
);

  typedef enum logic [2:0] {
    AT_START,
    IN_LEAD,
    IN_PLAIN,
    IN_QUOTED,
    AFTER_QUOTE,
    SKIP_REST
  } scan_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [5:0] column;
    logic       is_header;
    logic [1:0] code;
  } token_t;

  token_t     expected_tokens[$];
  logic [6:0] columns_cfg;
  logic       in_header;
  scan_t      scan;
  logic [6:0] col;
  logic       single_q;
  logic       halted;

  function automatic int active_columns();
    int n;
    n = int'(columns_cfg);
    if (n == 0) n = 1;
    if (n > MAX_COLUMNS_DEF) n = MAX_COLUMNS_DEF;
    return n;
  endfunction

  function automatic void push_token(input kind_t k, input logic [7:0] d, input logic [1:0] c);
    token_t t;
    t.kind      = k;
    t.data      = (k == K_BYTE) ? d : 8'd0;
    t.column    = (col > 7'd63) ? 6'd63 : col[5:0];
    t.is_header = in_header;
    t.code      = (k == K_ERR) ? c : ERR_NONE;
    expected_tokens.push_back(t);
    if (k == K_ERR) halted = 1'b1;
  endfunction

  function automatic void start_line();
    in_header = 1'b0;
    col       = 7'd0;
    scan      = AT_START;
    single_q  = 1'b0;
  endfunction

  function automatic void close_by_comma();
    if (int'(col) + 1 >= active_columns()) begin
      push_token(K_ROW, 8'd0, ERR_NONE);
      scan = SKIP_REST;
    end else begin
      push_token(K_FIELD, 8'd0, ERR_NONE);
      col      = col + 7'd1;
      scan     = AT_START;
      single_q = 1'b0;
    end
  endfunction

  function automatic void close_by_newline();
    if (int'(col) + 1 >= active_columns()) begin
      push_token(K_ROW, 8'd0, ERR_NONE);
      start_line();
    end else begin
      push_token(K_ERR, 8'd0, ERR_FEW_COLS);
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b);
    if (halted) return;
    if (in_header) begin
      if (b == CH_COMMA) begin
        push_token(K_FIELD, 8'd0, ERR_NONE);
        if (col < MAX_COLUMNS_DEF) col = col + 7'd1;
      end else if (b == CH_NL) begin
        if (int'(col) + 1 != active_columns()) push_token(K_ERR, 8'd0, ERR_HDR_CNT);
        else begin
          push_token(K_ROW, 8'd0, ERR_NONE);
          start_line();
        end
      end else begin
        push_token(K_BYTE, b, ERR_NONE);
      end
      return;
    end
    case (scan)
      AT_START, IN_LEAD: begin
        if (b == CH_NL) begin
          if (scan == AT_START) push_token(K_ERR, 8'd0, ERR_FEW_COLS);
          else close_by_newline();
        end else if (b == CH_SPACE) begin
          scan = IN_LEAD;
        end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
          single_q = (b == CH_SQUOTE);
          scan     = IN_QUOTED;
        end else if (b == CH_COMMA) begin
          close_by_comma();
        end else begin
          scan = IN_PLAIN;
          push_token(K_BYTE, b, ERR_NONE);
        end
      end
      IN_PLAIN: begin
        if (b == CH_NL) close_by_newline();
        else if (b == CH_COMMA) close_by_comma();
        else push_token(K_BYTE, b, ERR_NONE);
      end
      IN_QUOTED: begin
        if (b == CH_NL) close_by_newline();
        else if (b == (single_q ? CH_SQUOTE : CH_DQUOTE)) scan = AFTER_QUOTE;
        else push_token(K_BYTE, b, ERR_NONE);
      end
      AFTER_QUOTE: begin
        if (b == CH_NL) close_by_newline();
        else if (b == CH_COMMA) close_by_comma();
        else push_token(K_ERR, 8'd0, ERR_NO_COMMA);
      end
      default: begin
        // drop the rest of the line after the last column
        if (b == CH_NL) start_line();
      end
    endcase
  endfunction

  function automatic void report(input string what, input token_t exp, input token_t got);
    string exp_s;
    string got_s;
    exp_s = $sformatf("kind=%0d byte=%02h col=%0d hdr=%0b code=%0d",
                      exp.kind, exp.data, exp.column, exp.is_header, exp.code);
    got_s = $sformatf("kind=%0d byte=%02h col=%0d hdr=%0b code=%0d",
                      got.kind, got.data, got.column, got.is_header, got.code);
    if (mismatches < 10)
      $display("%0t %s: expected %s, got %s", $time, what, exp_s, got_s);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    token_t got;
    token_t exp;
    if (!rst_n) begin
      expected_tokens.delete();
      columns_cfg = CFG_COLUMNS_RST;
      halted      = 1'b0;
      start_line();
      in_header   = 1'b1;
    end else begin
      if (in_tvalid && in_tready) tokenize_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got.kind      = kind_t'(out_tuser[1:0]);
        got.is_header = out_tuser[2];
        got.data      = out_tdata[7:0];
        got.column    = out_tdata[13:8];
        got.code      = out_tdata[15:14];
        if (expected_tokens.size() == 0) begin
          exp = '0;
          report("unexpected result beat", exp, got);
        end else begin
          exp = expected_tokens.pop_front();
          if (got !== exp) report("token mismatch", exp, got);
        end
      end
      if (cfg_wr_en) columns_cfg = cfg_wr_data;
    end
    outstanding <= expected_tokens.size();
  end

endmodule

FILE: sim/csv_field_tokenizer_unit_tb.sv
// Testbench top: drives byte streams and column settings into the tokenizer and reports the verdict.
`timescale 1ns / 1ps

module csv_field_tokenizer_unit_tb;
  import csvft_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = 7'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] out_byte, [13:8] column, [15:14] error_code
  logic [2:0]  out_tuser;          // [1:0] kind, [2] is_header

  int         outstanding;
  int         mismatches;
  int         item_count = 0;
  bit         calm = 1'b0;
  bit         gappy = 1'b1;
  logic [6:0] cols_now = CFG_COLUMNS_RST;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  csv_field_tokenizer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  csv_field_tokenizer_unit_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  function automatic int row_width(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return int'(v);
  endfunction

  function automatic logic [7:0] plain_lead();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_NL || b == CH_COMMA || b == CH_SPACE || b == CH_DQUOTE || b == CH_SQUOTE);
    return b;
  endfunction

  function automatic logic [7:0] plain_tail();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_NL || b == CH_COMMA);
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte(input logic [7:0] q);
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_NL || b == q);
    return b;
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_NL);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit counted);
    if (!calm && gappy && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (counted) item_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1);
  endtask

  // Hold the input until every predicted token is out, then let the pipeline drain.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_columns(input logic [6:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cols_now = v;
  endtask

  task automatic send_field(input bit last, input bit comma_end);
    int         spaces;
    int         style;
    int         len;
    logic [7:0] q;
    spaces = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    style  = $urandom_range(0, 2);
    len    = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
    repeat (spaces) send_byte(CH_SPACE, 1'b1);
    if (style == 0) begin
      // an empty last field needs a space, or the newline lands at field start
      if (len == 0 && spaces == 0 && last && !comma_end) send_byte(CH_SPACE, 1'b1);
      for (int i = 0; i < len; i++) send_byte((i == 0) ? plain_lead() : plain_tail(), 1'b1);
    end else begin
      q = (style == 1) ? CH_DQUOTE : CH_SQUOTE;
      send_byte(q, 1'b1);
      for (int i = 0; i < len; i++) send_byte(quoted_byte(q), 1'b1);
      // leave the last quote open now and then; the newline closes it
      if (!(last && !comma_end && $urandom_range(0, 5) == 0)) send_byte(q, 1'b1);
    end
    send_byte(comma_end ? CH_COMMA : CH_NL, 1'b1);
  endtask

  task automatic send_row(input int n);
    bit tail;
    tail = ($urandom_range(0, 4) == 0);
    for (int c = 0; c < n; c++) send_field(c == n - 1, (c != n - 1) || tail);
    if (tail) begin
      repeat ($urandom_range(0, 10)) send_byte(junk_byte(), 1'b0);
      send_byte(CH_NL, 1'b0);
    end
  endtask

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    int guard;
    guard = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // header at the reset width of two columns
    send_text("',");
    send_byte(8'hFF, 1'b1);
    send_byte(CH_NL, 1'b1);
    // leading space, stray quote as content, comma inside single quotes
    send_text(" x\",',',\n");
    write_columns(7'd1);
    send_text("\"q\",z\n");
    write_columns(7'd0);
    send_text(" \n");
    write_columns(7'd3);
    send_text(",,\"a\n");
    // shrink the width mid-row: the current field becomes the last one
    write_columns(7'd4);
    send_text("a,");
    write_columns(7'd2);
    send_text("b,\n");

    while (item_count < 2000) begin
      if (row_width(cols_now) > 8 || $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 39))
          0:       write_columns(7'd0);
          1:       write_columns(7'd127);
          2:       write_columns(7'd64);
          3:       write_columns(7'($urandom_range(65, 127)));
          4, 5:    write_columns(7'd1);
          default: write_columns(7'($urandom_range(1, 6)));
        endcase
      end
      if (item_count >= 1800) calm = 1'b1;
      gappy = ($urandom_range(0, 3) != 0);
      send_row(row_width(cols_now));
    end

    // finish with one fatal error, then show that the halted block stays quiet
    calm = 1'b1;
    case ($urandom_range(0, 2))
      0: send_byte(CH_NL, 1'b1);
      1: send_text("\"A\"B");
      default: begin
        write_columns(7'd3);
        send_text("a\n");
      end
    endcase
    repeat (6) send_byte(8'($urandom), 1'b0);
    write_columns(7'd127);
    repeat (6) send_byte(8'($urandom), 1'b0);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
